FILE: design/assert_macros.svh
// Assertion macros used by the bloom filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`endif

FILE: design/bmf_pkg.sv
// Shared constants and types for the multi-hash bloom filter.
package bmf_pkg;
  localparam int POOL_BITS = 32768;
  localparam int ADDR_W    = $clog2(POOL_BITS);
  localparam int HASH_N    = 8;
  localparam int IDX_N     = 2 * HASH_N;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Hash slots, in store order.
  localparam int H_PJW  = 0;
  localparam int H_JS   = 1;
  localparam int H_RS   = 2;
  localparam int H_SDBM = 3;
  localparam int H_AP   = 4;
  localparam int H_DJB  = 5;
  localparam int H_BKDR = 6;
  localparam int H_ELF  = 7;

  typedef logic [HASH_N-1:0][31:0] hash_vec_t;

  localparam hash_vec_t HASH_SEED = {
    32'd0, 32'd0, 32'd5381, 32'd0, 32'd0, 32'd0, 32'd1315423911, 32'd0
  };
  localparam logic [31:0] RS_MULT_SEED = 32'd63689;
  localparam logic [31:0] RS_MULT_STEP = 32'd378551;
  localparam logic [31:0] BKDR_MULT    = 32'd131;
endpackage

FILE: design/bmf_hash.sv
// Running string hashes: one key byte folded in per cycle while absorb is high.
module bmf_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              absorb,
  input  logic              restart,
  input  logic [7:0]        key_byte,
  output bmf_pkg::hash_vec_t hash_nxt
);
  import bmf_pkg::*;

  hash_vec_t   hash_r;
  logic [31:0] rs_mult_r, rs_mult_nxt;
  logic        parity_r;
  logic [31:0] c, h, t, top, rs_prod, bk_prod;

  always_comb begin
    c = {{24{key_byte[7]}}, key_byte};
    hash_nxt = hash_r;

    t = {hash_r[H_PJW][27:0], 4'b0} + c;
    top = t & 32'hF000_0000;
    if (top != 32'd0) begin
      t = (t ^ (top >> 24)) & 32'h0FFF_FFFF;
    end
    hash_nxt[H_PJW] = t;

    h = hash_r[H_JS];
    hash_nxt[H_JS] = h ^ ((h << 5) + c + (h >> 2));

    rs_prod = hash_r[H_RS] * rs_mult_r;
    hash_nxt[H_RS] = rs_prod + c;
    rs_mult_nxt = rs_mult_r * RS_MULT_STEP;

    h = hash_r[H_SDBM];
    hash_nxt[H_SDBM] = c + (h << 6) + (h << 16) - h;

    h = hash_r[H_AP];
    if (!parity_r) begin
      hash_nxt[H_AP] = h ^ ((h << 7) ^ c ^ (h >> 3));
    end else begin
      hash_nxt[H_AP] = h ^ ~((h << 11) ^ c ^ (h >> 5));
    end

    h = hash_r[H_DJB];
    hash_nxt[H_DJB] = h + (h << 5) + c;

    bk_prod = hash_r[H_BKDR] * BKDR_MULT;
    hash_nxt[H_BKDR] = bk_prod + c;

    t = {hash_r[H_ELF][27:0], 4'b0} + c;
    top = t & 32'hF000_0000;
    if (top != 32'd0) begin
      t = (t ^ (top >> 24)) & ~top;
    end
    hash_nxt[H_ELF] = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      hash_r    <= HASH_SEED;
      rs_mult_r <= RS_MULT_SEED;
      parity_r  <= 1'b0;
    end else if (absorb) begin
      hash_r    <= hash_nxt;
      rs_mult_r <= rs_mult_nxt;
      parity_r  <= ~parity_r;
    end
  end
endmodule

FILE: design/multi_hash_bloom_filter.sv
// Top level of the multi-hash bloom filter: control, bit store and result port.
// Non-final key bytes leave busy low; a byte may follow every cycle. A final byte keeps busy
// high through a store access for each of the 16 indexes, a drain step and an emit step;
// the result strobe rises in the cycle after. Clear holds busy while it zeroes the store,
// one store row a cycle. Reset (rst_n low, synchronous) starts the same clearing pass with
// no result. Results cannot be stalled: out_valid is high for exactly one cycle per result.
module multi_hash_bloom_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  output logic        out_member_hit,
  output logic [31:0] out_objects_inserted
);
  import bmf_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_DRAIN, ST_EMIT} state_t;

  state_t      state_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic        clr_cmd_r;
  logic [3:0]  k_r;
  logic        ins_r;
  logic        hit_acc_r;
  logic [31:0] cnt_r;
  logic        out_valid_r, out_hit_r;

  // Store: row a holds bit a of each hash's pool, one bit per hash.
  logic [HASH_N-1:0] mem [POOL_BITS];
  logic [HASH_N-1:0] rdata_r;
  logic [ADDR_W-1:0] idx_r [IDX_N];

  // Modify stage and forwarding of the previous write.
  logic              s2_vld_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [2:0]        s2_pool_r;
  logic              wr_vld_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [HASH_N-1:0] wr_data_r;

  logic              accept, acc_item, acc_last, acc_clear;
  hash_vec_t         hash_nxt;
  logic [ADDR_W-1:0] rd_addr, waddr;
  logic [HASH_N-1:0] word, wdata;
  logic              we;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign acc_item  = accept && (in_kind == KIND_INSERT || in_kind == KIND_QUERY);
  assign acc_last  = acc_item && in_last_byte;
  assign acc_clear = accept && (in_kind == KIND_CLEAR);

  bmf_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .absorb   (acc_item),
    .restart  (acc_last || acc_clear),
    .key_byte (in_key_byte),
    .hash_nxt (hash_nxt)
  );

  // Read address for the current lookup step; forward the row written last cycle
  // when the modify stage hits the same row, since that read saw the old contents.
  always_comb begin
    rd_addr = idx_r[k_r];
    word    = (wr_vld_r && (wr_addr_r == s2_addr_r)) ? wr_data_r : rdata_r;
    if (state_r == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else begin
      we    = s2_vld_r && ins_r;
      waddr = s2_addr_r;
      wdata = word | (HASH_N'(1) << s2_pool_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r   <= mem[rd_addr];
    s2_addr_r <= rd_addr;
    s2_pool_r <= k_r[3:1];
    wr_addr_r <= waddr;
    wr_data_r <= wdata;
  end

  // Latch both indexes of every hash at the final byte.
  always_ff @(posedge clk) begin
    if (acc_last) begin
      for (int i = 0; i < HASH_N; i++) begin
        idx_r[2*i]   <= {7'd0, hash_nxt[i][7:0]};
        idx_r[2*i+1] <= hash_nxt[i][30:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_cmd_r   <= 1'b0;
      k_r         <= '0;
      ins_r       <= 1'b0;
      hit_acc_r   <= 1'b0;
      cnt_r       <= '0;
      s2_vld_r    <= 1'b0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      wr_vld_r    <= we;
      s2_vld_r    <= (state_r == ST_LOOK);
      if (s2_vld_r) begin
        hit_acc_r <= hit_acc_r & word[s2_pool_r];
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(POOL_BITS - 1)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= clr_cmd_r;
            out_hit_r   <= 1'b0;
            clr_cmd_r   <= 1'b0;
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (acc_clear) begin
            state_r    <= ST_CLEAR;
            clr_addr_r <= '0;
            clr_cmd_r  <= 1'b1;
            cnt_r      <= '0;
          end else if (acc_last) begin
            state_r   <= ST_LOOK;
            k_r       <= '0;
            hit_acc_r <= 1'b1;
            ins_r     <= (in_kind == KIND_INSERT);
            if (in_kind == KIND_INSERT && cnt_r != '1) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_LOOK: begin
          out_valid_r <= 1'b0;
          k_r <= k_r + 1'b1;
          if (k_r == 4'(IDX_N - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          out_valid_r <= 1'b0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          out_hit_r   <= hit_acc_r && !ins_r;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_member_hit       = out_hit_r;
  assign out_objects_inserted = cnt_r;

  `ASSERT_IMPL(a_write_only_busy, we, busy)
  `ASSERT_NEXT(a_last_goes_busy, acc_last, state_r == ST_LOOK)
  `ASSERT_IMPL(a_hit_only_query, out_valid && out_member_hit, !ins_r)
  `ASSERT_NEXT(a_clear_zeroes_count, acc_clear, cnt_r == 32'd0 && busy)
endmodule

FILE: bench/tb_multi_hash_bloom_filter.sv
// Self-checking testbench for the multi-hash bloom filter: directed and random key streams.
module tb_multi_hash_bloom_filter;
  import bmf_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key_byte;
    logic       last_byte;
  } key_item_t;

  typedef struct packed {
    logic        member_hit;
    logic [31:0] objects_inserted;
  } filter_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_key_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_member_hit;
  logic [31:0] out_objects_inserted;

  multi_hash_bloom_filter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_key_byte(in_key_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_member_hit(out_member_hit),
    .out_objects_inserted(out_objects_inserted)
  );

  always #1 clk = ~clk;

  // Predictor state: running hashes, RS multiplier, AP parity, stores and count.
  logic [31:0] run_hash [HASH_N];
  logic [31:0] rs_mult;
  logic        ap_odd;
  logic [POOL_BITS-1:0] pool [HASH_N];
  logic [31:0] key_count;

  key_item_t     pending_items [$];
  filter_reply_t expected_replies [$];
  int  errors = 0;
  int  replies_seen = 0;
  int  hits_seen = 0;
  int  accepted = 0;
  logic item_taken = 1'b0;

  function automatic void restart_hashes();
    for (int i = 0; i < HASH_N; i++) run_hash[i] = HASH_SEED[i];
    rs_mult = RS_MULT_SEED;
    ap_odd = 1'b0;
  endfunction

  function automatic void clear_filter();
    for (int i = 0; i < HASH_N; i++) pool[i] = '0;
    key_count = '0;
    restart_hashes();
  endfunction

  // Advance all eight hashes by one sign-extended byte.
  function automatic void absorb(logic [7:0] b);
    logic [31:0] c, h, top;
    c = {{24{b[7]}}, b};
    h = (run_hash[H_PJW] << 4) + c;
    top = h & 32'hF000_0000;
    if (top != 0) h = (h ^ (top >> 24)) & 32'h0FFF_FFFF;
    run_hash[H_PJW] = h;
    h = run_hash[H_JS];
    run_hash[H_JS] = h ^ ((h << 5) + c + (h >> 2));
    run_hash[H_RS] = run_hash[H_RS] * rs_mult + c;
    rs_mult = rs_mult * RS_MULT_STEP;
    h = run_hash[H_SDBM];
    run_hash[H_SDBM] = c + (h << 6) + (h << 16) - h;
    h = run_hash[H_AP];
    if (!ap_odd) h = h ^ ((h << 7) ^ c ^ (h >> 3));
    else h = h ^ ~((h << 11) ^ c ^ (h >> 5));
    run_hash[H_AP] = h;
    ap_odd = ~ap_odd;
    h = run_hash[H_DJB];
    run_hash[H_DJB] = h + (h << 5) + c;
    run_hash[H_BKDR] = run_hash[H_BKDR] * BKDR_MULT + c;
    h = (run_hash[H_ELF] << 4) + c;
    top = h & 32'hF000_0000;
    if (top != 0) begin
      h = h ^ (top >> 24);
      h = h & ~top;
    end
    run_hash[H_ELF] = h;
  endfunction

  // Apply one accepted item to the predictor; queue its reply if it makes one.
  function automatic void predict_filter(key_item_t it);
    filter_reply_t r;
    logic [31:0] hv;
    logic hit;
    hit = 1'b1;
    if (it.kind == KIND_CLEAR) begin
      clear_filter();
      r.member_hit = 1'b0;
      r.objects_inserted = '0;
      expected_replies.insert(expected_replies.size(), r);
      return;
    end
    if (it.kind == KIND_UNUSED) return;
    absorb(it.key_byte);
    if (!it.last_byte) return;
    for (int i = 0; i < HASH_N; i++) begin
      hv = run_hash[i] & 32'h7FFF_FFFF;
      if (it.kind == KIND_INSERT) begin
        pool[i][hv[7:0]] = 1'b1;
        pool[i][hv[30:16]] = 1'b1;
      end else if (!pool[i][hv[7:0]] || !pool[i][hv[30:16]]) begin
        hit = 1'b0;
      end
    end
    if (it.kind == KIND_INSERT) begin
      if (key_count != 32'hFFFF_FFFF) key_count++;
      hit = 1'b0;
    end
    restart_hashes();
    r.member_hit = hit;
    r.objects_inserted = key_count;
    expected_replies.insert(expected_replies.size(), r);
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Driver: present pending items, change inputs on the falling edge.
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // hold the item until accepted
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_items.size() > 0) begin
      key_item_t it;
      it = pending_items.pop_front();
      in_kind <= it.kind;
      in_key_byte <= it.key_byte;
      in_last_byte <= it.last_byte;
      start <= 1'b1;
      gap_left <= gap_len();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: feed the predictor on accepted items, check each reply strobe.
  int idle_cycles = 0;
  always @(posedge clk) begin
    item_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        predict_filter(key_item_t'{in_kind, in_key_byte, in_last_byte});
        accepted <= accepted + 1;
      end
      if (out_valid) begin
        replies_seen <= replies_seen + 1;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply hit=%0b count=%0d", $time,
                   out_member_hit, out_objects_inserted);
          errors = errors + 1;
        end else begin
          filter_reply_t e;
          e = expected_replies.pop_front();
          if (out_member_hit) hits_seen <= hits_seen + 1;
          if (e.member_hit !== out_member_hit) begin
            $display("%0t: member_hit expected %0b actual %0b", $time,
                     e.member_hit, out_member_hit);
            errors = errors + 1;
          end
          if (e.objects_inserted !== out_objects_inserted) begin
            $display("%0t: objects_inserted expected %0d actual %0d", $time,
                     e.objects_inserted, out_objects_inserted);
            errors = errors + 1;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d replies outstanding", $time,
                 expected_replies.size());
        $display("FAIL multi_hash_bloom_filter");
        $finish;
      end
    end
  end

  task automatic add_item(logic [1:0] k, logic [7:0] b, logic l);
    key_item_t it;
    it.kind = k;
    it.key_byte = b;
    it.last_byte = l;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Queue one whole key of random bytes; kind is mixed now and then.
  task automatic add_key(logic [1:0] k, int len);
    for (int i = 0; i < len; i++) begin
      logic [1:0] kk;
      kk = k;
      if ($urandom_range(15) == 0) kk = 2'($urandom_range(1));
      if (i == len - 1) kk = k;
      add_item(kk, 8'($urandom), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_replies.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  logic [7:0] saved_key [$];
  initial begin
    int n;
    clear_filter();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, single-byte keys, insert then query, unused kind,
    // clear mid-key, mixed kinds within one key.
    add_item(KIND_INSERT, 8'h00, 1'b1);
    add_item(KIND_QUERY, 8'h00, 1'b1);
    add_item(KIND_QUERY, 8'hFF, 1'b1);
    add_item(KIND_INSERT, 8'h80, 1'b0);
    add_item(KIND_INSERT, 8'h7F, 1'b0);
    add_item(KIND_INSERT, 8'hFF, 1'b1);
    add_item(KIND_QUERY, 8'h80, 1'b0);
    add_item(KIND_UNUSED, 8'h55, 1'b1);
    add_item(KIND_QUERY, 8'h7F, 1'b0);
    add_item(KIND_QUERY, 8'hFF, 1'b1);
    add_item(KIND_INSERT, 8'h41, 1'b0);
    add_item(KIND_QUERY, 8'h42, 1'b0);
    add_item(KIND_INSERT, 8'h43, 1'b1);
    add_item(KIND_QUERY, 8'h41, 1'b0);
    add_item(KIND_INSERT, 8'h42, 1'b0);
    add_item(KIND_QUERY, 8'h43, 1'b1);
    add_item(KIND_INSERT, 8'hAA, 1'b0);
    add_item(KIND_CLEAR, 8'hFF, 1'b1);
    add_item(KIND_QUERY, 8'h00, 1'b1);
    add_item(KIND_CLEAR, 8'h00, 1'b0);
    wait_drained();

    // Random: insert keys and query some of them back, plus fresh queries and noise.
    n = 0;
    while (n < 1130) begin
      int len, p;
      p = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
      if (p < 45) begin
        saved_key.delete();
        for (int i = 0; i < len; i++) begin
          saved_key.insert(saved_key.size(), 8'($urandom));
          add_item(KIND_INSERT, saved_key[i], i == len - 1);
        end
        if ($urandom_range(1)) begin
          for (int i = 0; i < len; i++)
            add_item(KIND_QUERY, saved_key[i], i == len - 1);
          n += len;
        end
      end else if (p < 85) begin
        add_key(KIND_QUERY, len);
      end else if (p < 95) begin
        add_item(KIND_UNUSED, 8'($urandom), 1'($urandom));
        len = 1;
      end else if (p < 97) begin
        add_item(KIND_CLEAR, 8'($urandom), 1'($urandom));
        len = 1;
      end else begin
        add_key(KIND_INSERT, len);
      end
      n += len;
      // Pause the sender until all replies are back, once in a while.
      if ($urandom_range(199) == 0 || (n > 500 && n < 520)) begin
        wait_drained();
      end
    end
    wait_drained();

    $display("Covered %0d items and %0d replies, %0d query hits.", accepted,
             replies_seen, hits_seen);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("PASS multi_hash_bloom_filter");
    end else begin
      $display("FAIL multi_hash_bloom_filter");
    end
    $finish;
  end
endmodule

FILE: multi_hash_bloom_filter.f
+incdir+design
design/bmf_pkg.sv
design/bmf_hash.sv
design/multi_hash_bloom_filter.sv
bench/tb_multi_hash_bloom_filter.sv
